// ----- sv/lslf_pkg.sv -----
package lslf_pkg;

   // Field widths of the point and result beats.
   localparam int KEY_W = 20;
   localparam int VAL_W = 32;

   // Largest store the block supports, and the widths that follow from it.
   localparam int MAX_POINTS_DEF = 64;
   localparam int CNT_W          = 7;
   localparam int IDX_W          = CNT_W - 1;

   // Running sum widths, sized for the largest store.
   localparam int SX_W  = 26;
   localparam int SY_W  = 38;
   localparam int SXX_W = 46;
   localparam int SXY_W = 58;

   // Divider operand widths.
   localparam int DIV_W  = 64;
   localparam int STEP_W = 7;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DEGEN = 2'd1,
      STAT_DROP  = 2'd2
   } fit_status_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PROD,
      B_DIFF,
      B_CHK,
      B_SDIV,
      B_IPROD,
      B_ISTART,
      B_IDIV,
      B_READ,
      B_FIT,
      B_PUSH
   } back_state_type;

   // One finished set, handed from the loader to the fit engine.
   typedef struct packed {
      logic                    bank;
      logic [CNT_W-1:0]        n;
      logic [SX_W-1:0]         sx;
      logic signed [SY_W-1:0]  sy;
      logic [SXX_W-1:0]        sxx;
      logic signed [SXY_W-1:0] sxy;
      logic                    dropped;
   } job_type;

   // Key store write from the loader.
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } key_wr_type;

endpackage

// ----- sv/lslf_if.sv -----
interface lslf_req_if;
   logic                            valid;
   logic                            ready;
   logic [lslf_pkg::KEY_W-1:0]      point_key;
   logic signed [lslf_pkg::VAL_W-1:0] point_value;
   logic                            set_end;

   modport source (output valid, point_key, point_value, set_end, input ready);
   modport sink   (input valid, point_key, point_value, set_end, output ready);
endinterface

interface lslf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lslf_pkg::KEY_W-1:0]        out_key;
   logic signed [lslf_pkg::VAL_W-1:0] fitted_value;
   logic signed [lslf_pkg::VAL_W-1:0] line_slope;
   logic signed [lslf_pkg::VAL_W-1:0] line_intercept;
   logic [1:0]                        fit_status;
   logic                              run_last;

   modport source (output valid, out_key, fitted_value, line_slope, line_intercept,
                   fit_status, run_last, input ready);
   modport sink   (input valid, out_key, fitted_value, line_slope, line_intercept,
                   fit_status, run_last, output ready);
endinterface

// ----- sv/lslf_front.sv -----
module lslf_front #(
   parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lslf_req_if.sink             req_chan,
   output lslf_pkg::key_wr_type key_wr,
   output logic                 job_push,
   output lslf_pkg::job_type    job_data,
   input  logic                 job_done
);
   import lslf_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);

   logic                     accept;
   logic                     store;
   logic [CW-1:0]            count_ff, count_in;
   logic                     dropped_ff, dropped_in;
   logic                     bank_ff, bank_in;
   logic [1:0]               pend_ff, pend_in;
   logic [SX_W-1:0]          sx_ff, sx_in;
   logic signed [SY_W-1:0]   sy_ff, sy_in;
   logic [SXX_W-1:0]         sxx_ff, sxx_in;
   logic signed [SXY_W-1:0]  sxy_ff, sxy_in;

   // Product stage between the accepted beat and the accumulators.
   logic                     s1_valid_ff;
   logic                     s1_last_ff;
   logic                     s1_store_ff;
   logic [KEY_W-1:0]         s1_key_ff;
   logic signed [VAL_W-1:0]  s1_val_ff;
   logic [2*KEY_W-1:0]       s1_kk_ff;
   logic signed [KEY_W+VAL_W:0] s1_kv_ff;

   // Hold off while a finished set waits to be queued or both banks are busy.
   assign req_chan.ready = (pend_ff < 2'd2) && !(s1_valid_ff && s1_last_ff);
   assign accept         = req_chan.valid && req_chan.ready;
   assign store          = count_ff < CW'(MAX_POINTS);
   assign job_push       = s1_valid_ff && s1_last_ff;

   // Keys go straight into the current bank of the store.
   always_comb begin
      key_wr.en   = accept && store;
      key_wr.bank = bank_ff;
      key_wr.idx  = IDX_W'(count_ff);
      key_wr.key  = req_chan.point_key;
   end

   // Accumulate the sums from the registered products of the accepted beat.
   always_comb begin
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      if (s1_valid_ff && s1_store_ff) begin
         sx_in  = sx_ff + SX_W'(s1_key_ff);
         sy_in  = sy_ff + SY_W'(s1_val_ff);
         sxx_in = sxx_ff + SXX_W'(s1_kk_ff);
         sxy_in = sxy_ff + SXY_W'(s1_kv_ff);
      end
   end

   always_comb begin
      job_data.bank    = bank_ff;
      job_data.n       = CNT_W'(count_ff);
      job_data.sx      = sx_in;
      job_data.sy      = sy_in;
      job_data.sxx     = sxx_in;
      job_data.sxy     = sxy_in;
      job_data.dropped = dropped_ff;
   end

   // Count, drop flag, bank and outstanding sets.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      bank_in    = bank_ff;
      if (accept) begin
         if (store) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (job_push) begin
         count_in   = '0;
         dropped_in = 1'b0;
         bank_in    = !bank_ff;
      end
      pend_in = pend_ff + {1'b0, job_push} - {1'b0, job_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         bank_ff     <= 1'b0;
         pend_ff     <= '0;
         s1_valid_ff <= 1'b0;
         sx_ff       <= '0;
         sy_ff       <= '0;
         sxx_ff      <= '0;
         sxy_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         bank_ff     <= bank_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= accept;
         if (job_push) begin
            sx_ff  <= '0;
            sy_ff  <= '0;
            sxx_ff <= '0;
            sxy_ff <= '0;
         end else begin
            sx_ff  <= sx_in;
            sy_ff  <= sy_in;
            sxx_ff <= sxx_in;
            sxy_ff <= sxy_in;
         end
      end
   end

   // Products of the accepted point.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff  <= req_chan.set_end;
         s1_store_ff <= store;
         s1_key_ff   <= req_chan.point_key;
         s1_val_ff   <= req_chan.point_value;
         s1_kk_ff    <= req_chan.point_key * req_chan.point_key;
         s1_kv_ff    <= $signed({1'b0, req_chan.point_key}) * req_chan.point_value;
      end
   end

endmodule

// ----- sv/lslf_job_fifo.sv -----
module lslf_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lslf_pkg::job_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output lslf_pkg::job_type pop_data
);
   import lslf_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign not_empty = fill_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointers and fill level; the loader never pushes into a full queue.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/lslf_div.sv -----
module lslf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lslf_pkg::DIV_W-1:0]   rem_init,
   input  logic [lslf_pkg::DIV_W-1:0]   dividend,
   input  logic [lslf_pkg::DIV_W-1:0]   divisor,
   input  logic [lslf_pkg::STEP_W-1:0]  steps,
   output logic                         done,
   output logic [lslf_pkg::DIV_W-1:0]   quotient
);
   import lslf_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  dsd_ff;
   logic [DIV_W-1:0]  dvs_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DIV_W:0]    trial;
   logic              fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One restoring step: bring down the next dividend bit and try the divisor.
   assign trial = {rem_ff, dsd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= steps;
         rem_ff <= rem_init;
         dsd_ff <= dividend;
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - STEP_W'(1);
         dsd_ff <= {dsd_ff[DIV_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? DIV_W'(trial - {1'b0, dvs_ff}) : DIV_W'(trial);
      end
   end

endmodule

// ----- sv/lslf_back.sv -----
module lslf_back #(
   parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lslf_pkg::key_wr_type key_wr,
   input  logic                 job_valid,
   input  lslf_pkg::job_type    job_in,
   output logic                 job_pop,
   output logic                 job_done,
   lslf_rsp_if.source           rsp_chan
);
   import lslf_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int AW = IW + 1;
   localparam logic [STEP_W-1:0] SLOPE_STEPS = STEP_W'(32);
   localparam logic [STEP_W-1:0] ICPT_STEPS  = STEP_W'(64);
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   back_state_type state_ff, state_in;

   // Key store, two banks so the next set can load during emission.
   logic [KEY_W-1:0] key_mem [2**AW];
   logic [KEY_W-1:0] rd_key_ff;

   job_type                     job_ff;
   logic signed [CNT_W+SXY_W:0] p_nsxy_ff;
   logic signed [SX_W+SY_W:0]   p_sxsy_ff;
   logic [CNT_W+SXX_W-1:0]      p_nsxx_ff;
   logic [2*SX_W-1:0]           p_sxsx_ff;
   logic signed [DIV_W-1:0]     num_ff;
   logic [DIV_W-1:0]            den_ff;
   logic signed [VAL_W-1:0]     slope_ff;
   logic signed [VAL_W-1:0]     icpt_ff;
   logic signed [VAL_W+SX_W:0]  iprod_ff;
   logic                        ineg_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic [KEY_W-1:0]            key_ff;
   logic signed [KEY_W+VAL_W:0] fitp_ff;

   logic                        rsp_valid_ff;
   logic [KEY_W-1:0]            rsp_key_ff;
   logic signed [VAL_W-1:0]     rsp_fit_ff;
   logic signed [VAL_W-1:0]     rsp_slope_ff;
   logic signed [VAL_W-1:0]     rsp_icpt_ff;
   logic [1:0]                  rsp_status_ff;
   logic                        rsp_last_ff;

   logic                        num_neg;
   logic [DIV_W-1:0]            num_mag;
   logic                        slope_ovf;
   logic signed [VAL_W+SX_W+1:0] inum;
   logic [DIV_W-1:0]            inum_mag;
   logic                        is_last;
   logic                        out_free;
   logic signed [KEY_W+VAL_W+1:0] fit_sum;
   logic signed [VAL_W-1:0]     fit_sat;
   fit_status_type              status;

   logic                        div_start;
   logic [DIV_W-1:0]            div_rem;
   logic [DIV_W-1:0]            div_dsd;
   logic [DIV_W-1:0]            div_dvs;
   logic [STEP_W-1:0]           div_steps;
   logic                        div_done;
   logic [DIV_W-1:0]            div_quo;

   // Clamp a sign and magnitude to the Q16.16 range.
   function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                       input logic [DIV_W-1:0] mag);
      logic signed [VAL_W-1:0] res;
      if (!neg && mag > DIV_W'(VAL_MAX)) begin
         res = VAL_MAX;
      end else if (neg && mag > {{(DIV_W-VAL_W){1'b0}}, VAL_MIN}) begin
         res = VAL_MIN;
      end else if (neg) begin
         res = VAL_W'(-mag);
      end else begin
         res = VAL_W'(mag);
      end
      return res;
   endfunction

   lslf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .dividend (div_dsd),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Slope quotient is known to fit when the magnitude is below den * 2^16.
   assign num_neg   = num_ff[DIV_W-1];
   assign num_mag   = num_neg ? DIV_W'(-num_ff) : DIV_W'(num_ff);
   assign slope_ovf = {16'b0, num_mag} >= {den_ff, 16'b0};

   // Intercept numerator: sum of values less slope times sum of keys.
   assign inum     = (VAL_W+SX_W+2)'(job_ff.sy) - (VAL_W+SX_W+2)'(iprod_ff);
   assign inum_mag = inum[VAL_W+SX_W+1] ? DIV_W'(-inum) : DIV_W'(inum);

   assign is_last  = idx_ff == job_ff.n - CNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fit_sum  = (KEY_W+VAL_W+2)'(fitp_ff) + (KEY_W+VAL_W+2)'(icpt_ff);
   assign fit_sat  = (fit_sum > (KEY_W+VAL_W+2)'(VAL_MAX)) ? VAL_MAX :
                     (fit_sum < (KEY_W+VAL_W+2)'(VAL_MIN)) ? VAL_MIN :
                     VAL_W'(fit_sum);
   assign status   = job_ff.dropped ? STAT_DROP :
                     (den_ff == '0) ? STAT_DEGEN : STAT_OK;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (job_valid) state_in = B_PROD;
         B_PROD:   state_in = B_DIFF;
         B_DIFF:   state_in = B_CHK;
         B_CHK:    state_in = (den_ff == '0 || slope_ovf) ? B_IPROD : B_SDIV;
         B_SDIV:   if (div_done) state_in = B_IPROD;
         B_IPROD:  state_in = B_ISTART;
         B_ISTART: state_in = B_IDIV;
         B_IDIV:   if (div_done) state_in = B_READ;
         B_READ:   state_in = B_FIT;
         B_FIT:    state_in = B_PUSH;
         B_PUSH:   if (out_free) state_in = is_last ? B_IDLE : B_READ;
         default:  state_in = B_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      job_pop   = 1'b0;
      job_done  = 1'b0;
      div_start = 1'b0;
      div_rem   = {16'b0, num_mag[DIV_W-1:16]};
      div_dsd   = {num_mag[15:0], {(DIV_W-16){1'b0}}};
      div_dvs   = den_ff;
      div_steps = SLOPE_STEPS;
      case (state_ff)
         B_IDLE:   job_pop = job_valid;
         B_CHK:    div_start = (den_ff != '0) && !slope_ovf;
         B_ISTART: begin
            div_start = 1'b1;
            div_rem   = '0;
            div_dsd   = inum_mag;
            div_dvs   = DIV_W'(job_ff.n);
            div_steps = ICPT_STEPS;
         end
         B_PUSH:   job_done = out_free && is_last;
         default:  job_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Key store ports.
   always_ff @(posedge clock) begin
      if (key_wr.en) begin
         key_mem[{key_wr.bank, key_wr.idx[IW-1:0]}] <= key_wr.key;
      end
      if (state_ff == B_READ) begin
         rd_key_ff <= key_mem[{job_ff.bank, idx_ff[IW-1:0]}];
      end
   end

   // Fit datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE:   job_ff <= job_in;
         B_PROD: begin
            p_nsxy_ff <= $signed({1'b0, job_ff.n}) * job_ff.sxy;
            p_sxsy_ff <= $signed({1'b0, job_ff.sx}) * job_ff.sy;
            p_nsxx_ff <= job_ff.n * job_ff.sxx;
            p_sxsx_ff <= job_ff.sx * job_ff.sx;
         end
         B_DIFF: begin
            num_ff <= DIV_W'(p_nsxy_ff - (CNT_W+SXY_W+1)'(p_sxsy_ff));
            den_ff <= DIV_W'(p_nsxx_ff) - DIV_W'(p_sxsx_ff);
         end
         B_CHK: begin
            if (den_ff == '0) begin
               slope_ff <= '0;
            end else if (slope_ovf) begin
               slope_ff <= num_neg ? VAL_MIN : VAL_MAX;
            end
         end
         B_SDIV: begin
            if (div_done) begin
               slope_ff <= sat_mag(num_neg, {{(DIV_W-32){1'b0}}, div_quo[31:0]});
            end
         end
         B_IPROD:  iprod_ff <= slope_ff * $signed({1'b0, job_ff.sx});
         B_ISTART: ineg_ff <= inum[VAL_W+SX_W+1];
         B_IDIV: begin
            idx_ff <= '0;
            if (div_done) begin
               icpt_ff <= sat_mag(ineg_ff, div_quo);
            end
         end
         B_FIT: begin
            key_ff  <= rd_key_ff;
            fitp_ff <= $signed({1'b0, rd_key_ff}) * slope_ff;
         end
         B_PUSH: begin
            if (out_free) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         default: idx_ff <= idx_ff;
      endcase
   end

   // Output register toward the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == B_PUSH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The line travels with each beat, so a waiting beat keeps it while the next fit starts.
   always_ff @(posedge clock) begin
      if (state_ff == B_PUSH && out_free) begin
         rsp_key_ff    <= key_ff;
         rsp_fit_ff    <= fit_sat;
         rsp_slope_ff  <= slope_ff;
         rsp_icpt_ff   <= icpt_ff;
         rsp_status_ff <= status;
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_key        = rsp_key_ff;
   assign rsp_chan.fitted_value   = rsp_fit_ff;
   assign rsp_chan.line_slope     = rsp_slope_ff;
   assign rsp_chan.line_intercept = rsp_icpt_ff;
   assign rsp_chan.fit_status     = rsp_status_ff;
   assign rsp_chan.run_last       = rsp_last_ff;

endmodule

// ----- sv/least_squares_line_fit_unit.sv -----
// Least-squares line fit over sets of up to MAX_POINTS points. Points load at one
// beat per cycle while a key store bank is free; ready drops in the cycle after the
// last point of a set (set_end), which closes it. The fit engine then returns one beat
// per stored point, in load order, carrying the key, its fitted value, the slope, the
// intercept and the status. Once a set reaches the engine, it takes the set, forms the
// products and differences, runs the slope division (skipped when the set is
// degenerate or the slope saturates), forms the intercept numerator, runs the
// intercept division, and then for each emitted point reads the key store, multiplies
// and registers the output, waiting there while the output is held. The key store has
// two banks, so one further set can load while a fit runs; a third set waits until the
// running fit has handed its last beat to the output register.
module least_squares_line_fit_unit #(
   parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
   input logic        clock,
   input logic        reset,
   lslf_req_if.sink   req_chan,
   lslf_rsp_if.source rsp_chan
);
   import lslf_pkg::*;

   key_wr_type key_wr;
   logic       job_push;
   job_type    job_push_data;
   logic       job_pop;
   logic       job_valid;
   job_type    job_head;
   logic       job_done;

   lslf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .key_wr   (key_wr),
      .job_push (job_push),
      .job_data (job_push_data),
      .job_done (job_done)
   );

   lslf_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (job_head)
   );

   lslf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .key_wr    (key_wr),
      .job_valid (job_valid),
      .job_in    (job_head),
      .job_pop   (job_pop),
      .job_done  (job_done),
      .rsp_chan  (rsp_chan)
   );

endmodule
